// ===== src/plm_pkg.sv =====
// Shared types and constants for the positional insert/delete list.
package plm_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

// ===== src/plm_ram.sv =====
// Entry store: one write port, one read port, registered read data.
module plm_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6
) (
  input  logic                  clk,
  input  plm_pkg::ram_ctl_t     ctl,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);
  import plm_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/positional_insert_delete_list.sv =====
// Top level: positional insert/delete list over a single entry store.
//
//  channel  | handshake              | fields
//  ---------+------------------------+--------------------------
//  request  | start / busy           | kind, position, value
//  result   | done (one-cycle pulse) | ok, read_value, count
//  config   | cfg_valid / cfg_ready  | cfg_data (capacity_in_use)
//
// Clear, rejected requests, insert at the fill and delete of the last entry
// finish from idle; a get reads the store first; other inserts shift up, then
// write. Other deletes shift down. The shift moves one entry per cycle through
// the store's read and write ports. Synchronous reset empties the list; no
// clearing pass. Results cannot be stalled; busy is high while a shift runs.
module positional_insert_delete_list #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [6:0]  position,
  input  logic [31:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic        ok,
  output logic [31:0] read_value,
  output logic [6:0]  count
);
  import plm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int PW = (FW > 7) ? FW : 7;
  localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GET  = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;

  logic [2:0]            state, state_next;
  logic [FW-1:0]         fill, fill_next;
  logic [6:0]            cap;
  logic [AW-1:0]         rptr, rptr_next;
  logic [AW-1:0]         pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  done_next, ok_next;
  logic [DATA_WIDTH-1:0] rd_next;

  ram_ctl_t              ctl;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  logic [PW-1:0]         pos_x, fill_x, cap_x, fdec_x;
  logic [FW-1:0]         fill_dec, fill_inc;
  logic [AW-1:0]         pos_a;
  logic [XW-1:0]         value_x, rd_x, fill_out_x;
  logic [DATA_WIDTH-1:0] val_m;
  logic                  ins_ok, rd_ok;
  logic [PW-1:0]         cnt_x;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign pos_x    = PW'(position);
  assign fill_x   = PW'(fill);
  assign cap_x    = PW'(cap);
  assign fill_dec = fill - FW'(1);
  assign fill_inc = fill + FW'(1);
  assign fdec_x   = PW'(fill_dec);
  assign pos_a    = pos_x[AW-1:0];
  assign value_x  = XW'(value);
  assign val_m    = value_x[DATA_WIDTH-1:0];
  assign ins_ok   = (fill_x < cap_x) && (fill_x < PW'(DEPTH)) && (pos_x <= fill_x);
  assign rd_ok    = (pos_x < fill_x);

  always_comb begin
    state_next = state;
    fill_next  = fill;
    rptr_next  = rptr;
    ctl        = '0;
    raddr      = rptr;
    waddr      = rptr;
    wdata      = rdata;
    done_next  = 1'b0;
    ok_next    = 1'b0;
    rd_next    = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind)
            OP_INSERT: begin
              if (!ins_ok) begin
                done_next = 1'b1;
              end else if (pos_x == fill_x) begin
                ctl.we    = 1'b1;
                waddr     = pos_a;
                wdata     = val_m;
                fill_next = fill_inc;
                done_next = 1'b1;
                ok_next   = 1'b1;
              end else begin
                ctl.re     = 1'b1;
                raddr      = fill_dec[AW-1:0];
                rptr_next  = fill_dec[AW-1:0];
                state_next = S_UP;
              end
            end
            OP_DELETE: begin
              if (!rd_ok) begin
                done_next = 1'b1;
              end else if (pos_x == fdec_x) begin
                fill_next = fill_dec;
                done_next = 1'b1;
                ok_next   = 1'b1;
              end else begin
                ctl.re     = 1'b1;
                raddr      = pos_a + AW'(1);
                rptr_next  = pos_a + AW'(1);
                state_next = S_DN;
              end
            end
            OP_GET: begin
              if (!rd_ok) begin
                done_next = 1'b1;
              end else begin
                ctl.re     = 1'b1;
                raddr      = pos_a;
                state_next = S_GET;
              end
            end
            default: begin
              fill_next = '0;
              done_next = 1'b1;
              ok_next   = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        done_next  = 1'b1;
        ok_next    = 1'b1;
        rd_next    = rdata;
        state_next = S_IDLE;
      end
      S_UP: begin
        ctl.we = 1'b1;
        waddr  = rptr + AW'(1);
        wdata  = rdata;
        if (rptr == pos_r) begin
          state_next = S_INS;
        end else begin
          ctl.re    = 1'b1;
          raddr     = rptr - AW'(1);
          rptr_next = rptr - AW'(1);
        end
      end
      S_INS: begin
        ctl.we     = 1'b1;
        waddr      = pos_r;
        wdata      = val_r;
        fill_next  = fill_inc;
        done_next  = 1'b1;
        ok_next    = 1'b1;
        state_next = S_IDLE;
      end
      S_DN: begin
        ctl.we = 1'b1;
        waddr  = rptr - AW'(1);
        wdata  = rdata;
        if (FW'(rptr) == fill_dec) begin
          fill_next  = fill_dec;
          done_next  = 1'b1;
          ok_next    = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.re    = 1'b1;
          raddr     = rptr + AW'(1);
          rptr_next = rptr + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rd_x       = XW'(rd_next);
  assign cnt_x      = PW'(fill_next);
  assign fill_out_x = XW'(cnt_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      cap   <= CAP_RESET;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rptr <= rptr_next;
    if (start && !busy) begin
      pos_r <= pos_a;
      val_r <= val_m;
    end
    if (done_next) begin
      ok         <= ok_next;
      read_value <= rd_x[31:0];
      count      <= fill_out_x[6:0];
    end
  end

  plm_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither busy nor done");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (read_value == '0))
    else $error("rejected item returned data");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill beyond depth");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (ctl.we && ctl.re) |-> (waddr != raddr))
    else $error("read and write to the same entry");

  a_shift_writes: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP || state == S_DN || state == S_INS) |-> ctl.we)
    else $error("shift cycle without write");
`endif

endmodule

// ===== dv/positional_insert_delete_list_tb.sv =====
// Self-checking testbench for the positional insert/delete list.
`timescale 1ns / 100ps

module positional_insert_delete_list_tb;
  import plm_pkg::*;

  localparam int          DEPTH          = 64;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 188;
  localparam int unsigned QUIET_FROM     = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES    = 80;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [6:0]  count;
  } list_outcome_t;

  // Shadow copy of the list: predicts the outcome of each accepted item.
  class shadow_list;
    logic [31:0]   store [DEPTH];
    int unsigned   fill_level;
    int unsigned   capacity;
    list_outcome_t pending_outcomes [$];
    int unsigned   mismatches;

    function new();
      fill_level = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [6:0] c);
      capacity = c;
    endfunction

    function void apply_op(logic [1:0] k, logic [6:0] p, logic [31:0] v);
      list_outcome_t o;
      int unsigned   limit;
      int            i;
      o     = '0;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      case (k)
        OP_INSERT: begin
          if (fill_level < limit && p <= fill_level && fill_level < DEPTH) begin
            for (i = fill_level; i > p; i--) store[i] = store[i-1];
            store[p] = v;
            fill_level++;
            o.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          if (p < fill_level) begin
            for (i = p; i + 1 < fill_level; i++) store[i] = store[i+1];
            fill_level--;
            o.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (p < fill_level) begin
            o.read_value = store[p];
            o.ok         = 1'b1;
          end
        end
        default: begin
          fill_level = 0;
          o.ok       = 1'b1;
        end
      endcase
      o.count = 7'(fill_level);
      pending_outcomes.push_back(o);
    endfunction

    function void check_outcome(logic ok_i, logic [31:0] rd_i, logic [6:0] cnt_i);
      list_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
        return;
      end
      o = pending_outcomes.pop_front();
      if (ok_i !== o.ok) begin
        $error("ok: expected %0d, got %0d", o.ok, ok_i);
        mismatches++;
      end
      if (rd_i !== o.read_value) begin
        $error("read_value: expected %h, got %h", o.read_value, rd_i);
        mismatches++;
      end
      if (cnt_i !== o.count) begin
        $error("count: expected %0d, got %0d", o.count, cnt_i);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [1:0]  kind      = OP_CLEAR;
  logic [6:0]  position  = '0;
  logic [31:0] value     = '0;
  logic        cfg_valid = 1'b0;
  logic [6:0]  cfg_data  = '0;
  logic        busy;
  logic        cfg_ready;
  logic        done;
  logic        ok;
  logic [31:0] read_value;
  logic [6:0]  count;

  shadow_list  sh = new();
  int unsigned idle_cycles = 0;
  bit          active;

  positional_insert_delete_list i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .position   (position),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .ok         (ok),
    .read_value (read_value),
    .count      (count)
  );

  always #5 clk = ~clk;

  // Acceptance, result checking and watchdog share one process so that an
  // item is always noted before its result can be checked.
  always @(posedge clk) begin
    if (!rst) begin
      active = 1'b0;
      if (cfg_valid && cfg_ready) begin
        sh.set_capacity(cfg_data);
        active = 1'b1;
      end
      if (start && !busy) begin
        sh.apply_op(kind, position, value);
        active = 1'b1;
      end
      if (done) begin
        sh.check_outcome(ok, read_value, count);
        active = 1'b1;
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Leaves start high; caller lowers it or issues the next item.
  task automatic issue(input logic [1:0] k, input logic [6:0] p, input logic [31:0] v);
    start    <= 1'b1;
    kind     <= k;
    position <= p;
    value    <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sh.pending_outcomes.size() != 0 || busy);
  endtask

  task automatic write_capacity(input logic [6:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned sent;
    int unsigned ins_pct;
    int unsigned del_top;
    int unsigned r;
    logic [1:0]  k;
    logic [6:0]  p;
    logic [31:0] v;
    logic [6:0]  phase_caps [PHASES];

    phase_caps[0] = 7'd127;
    phase_caps[1] = 7'd2;
    phase_caps[2] = 7'd64;
    phase_caps[3] = 7'($urandom_range(3, 63));
    phase_caps[4] = 7'd1;
    phase_caps[5] = 7'($urandom_range(65, 126));
    phase_caps[6] = 7'd0;
    phase_caps[7] = 7'd64;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, then build and read back, out-of-range positions
    issue(OP_GET,    7'd0,   32'h0);
    issue(OP_DELETE, 7'd0,   32'h0);
    issue(OP_INSERT, 7'd1,   32'h1234_5678);
    issue(OP_INSERT, 7'd0,   32'h0000_0000);
    issue(OP_INSERT, 7'd1,   32'hFFFF_FFFF);
    issue(OP_INSERT, 7'd1,   32'hA5A5_5A5A);
    issue(OP_INSERT, 7'd0,   32'h5A5A_A5A5);
    issue(OP_GET,    7'd0,   32'h0);
    issue(OP_GET,    7'd1,   32'h0);
    issue(OP_GET,    7'd2,   32'h0);
    issue(OP_GET,    7'd3,   32'h0);
    issue(OP_GET,    7'd4,   32'h0);
    issue(OP_GET,    7'd127, 32'hFFFF_FFFF);
    issue(OP_INSERT, 7'd127, 32'hFFFF_FFFF);
    issue(OP_DELETE, 7'd1,   32'h0);
    issue(OP_DELETE, 7'd2,   32'h0);
    issue(OP_DELETE, 7'd64,  32'h0);
    issue(OP_GET,    7'd0,   32'h0);
    issue(OP_CLEAR,  7'd0,   32'h0);
    issue(OP_GET,    7'd0,   32'h0);
    settle();

    // capacity of one: full after a single insert
    write_capacity(7'd1);
    issue(OP_INSERT, 7'd0, 32'hDEAD_BEEF);
    issue(OP_INSERT, 7'd1, 32'h0BAD_F00D);
    issue(OP_GET,    7'd0, 32'h0);
    settle();

    // capacity zero, also below the current fill
    write_capacity(7'd0);
    issue(OP_INSERT, 7'd0, 32'h1111_1111);
    issue(OP_DELETE, 7'd0, 32'h0);
    issue(OP_INSERT, 7'd0, 32'h2222_2222);

    sent = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_capacity(phase_caps[ph]);
      ins_pct = $urandom_range(30, 75);
      del_top = ins_pct + (98 - ins_pct) / 2;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) k = OP_INSERT;
        else if (r < del_top) k = OP_DELETE;
        else if (r < 98) k = OP_GET;
        else k = OP_CLEAR;
        if ($urandom_range(0, 9) == 0) p = 7'($urandom_range(0, 127));
        else if (k == OP_INSERT) p = 7'($urandom_range(0, sh.fill_level));
        else if (sh.fill_level == 0) p = 7'd0;
        else p = 7'($urandom_range(0, sh.fill_level - 1));
        v = $urandom;
        issue(k, p, v);
        sent++;
        if (sent < QUIET_FROM && $urandom_range(0, 9) < 3) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sh.mismatches == 0 && sh.pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
